FILE: sv/pidhc_pkg.sv
// ----------------------------------------------------------------------------
// PID heater controller package
// Shared widths, reset values, register indexes and types.
// ----------------------------------------------------------------------------
package pidhc_pkg;

   localparam int GAIN_FRAC_BITS_DEF = 16;
   localparam int SUM_WIDTH_DEF      = 32;

   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 24;
   localparam int ERR_W       = SAMPLE_W + 1;
   localparam int DERIV_W     = ERR_W + 1;
   localparam int DRIVE_W     = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [SAMPLE_W-1:0] SETPOINT_RST = 16'd1600;
   localparam logic [GAIN_W-1:0]   GAIN_P_RST   = 24'd1311;
   localparam logic [GAIN_W-1:0]   GAIN_I_RST   = 24'd0;
   localparam logic [GAIN_W-1:0]   GAIN_D_RST   = 24'd0;

   localparam logic [DRIVE_W-1:0] DRIVE_MAX = 16'h7fff;
   localparam logic [DRIVE_W-1:0] DRIVE_MIN = 16'h8000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SETPOINT = 2'd0,
      CSR_GAIN_P   = 2'd1,
      CSR_GAIN_I   = 2'd2,
      CSR_GAIN_D   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
   } gains_type;

endpackage

FILE: sv/pidhc_front.sv
// ----------------------------------------------------------------------------
// PID heater controller front end
// Accepts sample words, forms error and derivative, and keeps the error state.
// ----------------------------------------------------------------------------
module pidhc_front #(
   parameter int SUM_WIDTH = pidhc_pkg::SUM_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [pidhc_pkg::SAMPLE_W-1:0]       setpoint,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [pidhc_pkg::SAMPLE_W-1:0]       sample,
   input  logic                                 water,
   input  logic                                 queue_ready,
   output logic                                 push,
   output logic [pidhc_pkg::ERR_W+pidhc_pkg::DERIV_W+SUM_WIDTH:0] push_data
);

   localparam int ERR_W   = pidhc_pkg::ERR_W;
   localparam int DERIV_W = pidhc_pkg::DERIV_W;

   logic signed [ERR_W-1:0]     prev_err_ff;
   logic signed [SUM_WIDTH-1:0] sum_ff;
   logic signed [ERR_W-1:0]     err;
   logic signed [DERIV_W-1:0]   deriv;
   logic signed [SUM_WIDTH:0]   sum_wide;
   logic signed [SUM_WIDTH-1:0] sum_in;

   assign in_ready = queue_ready;
   assign push     = in_valid & queue_ready;

   assign err   = {setpoint[pidhc_pkg::SAMPLE_W-1], setpoint}
                - {sample[pidhc_pkg::SAMPLE_W-1], sample};
   assign deriv = {err[ERR_W-1], err} - {prev_err_ff[ERR_W-1], prev_err_ff};

   assign sum_wide = {sum_ff[SUM_WIDTH-1], sum_ff}
                   + {{(SUM_WIDTH+1-ERR_W){err[ERR_W-1]}}, err};

   always_comb begin
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_in = {sum_wide[SUM_WIDTH], {(SUM_WIDTH-1){~sum_wide[SUM_WIDTH]}}};
      end else begin
         sum_in = sum_wide[SUM_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         sum_ff      <= '0;
      end else if (push && water) begin
         prev_err_ff <= err;
         sum_ff      <= sum_in;
      end
   end

   assign push_data = {water, sum_ff, deriv, err};

endmodule

FILE: sv/pidhc_queue.sv
// ----------------------------------------------------------------------------
// PID heater controller queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module pidhc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pidhc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/pidhc_back.sv
// ----------------------------------------------------------------------------
// PID heater controller back end
// Multiplies the terms by the gains, sums, scales and saturates the drive.
// ----------------------------------------------------------------------------
module pidhc_back #(
   parameter int GAIN_FRAC_BITS = pidhc_pkg::GAIN_FRAC_BITS_DEF,
   parameter int SUM_WIDTH      = pidhc_pkg::SUM_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pidhc_pkg::gains_type                 gains,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [pidhc_pkg::ERR_W+pidhc_pkg::DERIV_W+SUM_WIDTH:0] in_data,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [pidhc_pkg::DRIVE_W-1:0]        drive,
   output logic                                 saturated
);

   localparam int ERR_W   = pidhc_pkg::ERR_W;
   localparam int DERIV_W = pidhc_pkg::DERIV_W;
   localparam int GAIN_W  = pidhc_pkg::GAIN_W;
   localparam int DRIVE_W = pidhc_pkg::DRIVE_W;
   localparam int LO_W    = SUM_WIDTH / 2;
   localparam int HI_W    = SUM_WIDTH - LO_W;
   localparam int TOT_W   = SUM_WIDTH + GAIN_W + 2;
   localparam int WATER_B = ERR_W + DERIV_W + SUM_WIDTH;

   logic                         adv;
   logic signed [ERR_W-1:0]      err;
   logic signed [DERIV_W-1:0]    deriv;
   logic [SUM_WIDTH-1:0]         sum;

   logic                         v1_ff, v2_ff, v3_ff;
   logic                         w1_ff, w2_ff, w3_ff;
   logic signed [GAIN_W+ERR_W-1:0]   p1_ff;
   logic signed [GAIN_W+DERIV_W-1:0] d1_ff;
   logic signed [GAIN_W+LO_W:0]      ilo1_ff;
   logic signed [GAIN_W+HI_W-1:0]    ihi1_ff;
   logic signed [TOT_W-1:0]      it2_ff, pd2_ff, tot3_ff;
   logic signed [TOT_W-1:0]      shifted;
   logic [TOT_W-DRIVE_W:0]       upper;
   logic                         fits;

   logic                         out_valid_ff;
   logic [DRIVE_W-1:0]           drive_ff, drive_in;
   logic                         sat_ff, sat_in;

   assign adv      = !out_valid_ff || out_ready;
   assign in_ready = adv;

   assign err   = in_data[ERR_W-1:0];
   assign deriv = in_data[ERR_W+DERIV_W-1:ERR_W];
   assign sum   = in_data[WATER_B-1:ERR_W+DERIV_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w1_ff   <= in_data[WATER_B];
         p1_ff   <= $signed(gains.gain_p) * err;
         d1_ff   <= $signed(gains.gain_d) * deriv;
         ilo1_ff <= $signed(gains.gain_i) * $signed({1'b0, sum[LO_W-1:0]});
         ihi1_ff <= $signed(gains.gain_i) * $signed(sum[SUM_WIDTH-1:LO_W]);
         w2_ff   <= w1_ff;
         it2_ff  <= (TOT_W'(ihi1_ff) <<< LO_W) + TOT_W'(ilo1_ff);
         pd2_ff  <= TOT_W'(p1_ff) + TOT_W'(d1_ff);
         w3_ff   <= w2_ff;
         tot3_ff <= it2_ff + pd2_ff;
         drive_ff <= drive_in;
         sat_ff   <= sat_in;
      end
   end

   assign shifted = tot3_ff >>> GAIN_FRAC_BITS;
   assign upper   = shifted[TOT_W-1:DRIVE_W-1];
   assign fits    = (&upper) || !(|upper);

   always_comb begin
      drive_in = '0;
      sat_in   = 1'b0;
      if (w3_ff) begin
         if (fits) begin
            drive_in = shifted[DRIVE_W-1:0];
         end else begin
            drive_in = shifted[TOT_W-1] ? pidhc_pkg::DRIVE_MIN : pidhc_pkg::DRIVE_MAX;
            sat_in   = 1'b1;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign drive     = drive_ff;
   assign saturated = sat_ff;

endmodule

FILE: sv/pid_heater_controller.sv
// ----------------------------------------------------------------------------
// PID heater controller
// Turns temperature sample words into heater drive words with a PID law.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is not stalled, set by the four-stage multiply pipeline.
// The four-entry queue lets the input keep flowing while the output stalls, until it is full.
// Reset is synchronous and active high; it restores register defaults and
// clears the error history, the queue and the pipeline.
module pid_heater_controller #(
   parameter int GAIN_FRAC_BITS = pidhc_pkg::GAIN_FRAC_BITS_DEF,
   parameter int SUM_WIDTH      = pidhc_pkg::SUM_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [15:0]                           req_tdata,  // [15:0] temp_sample
   input  logic [0:0]                            req_tuser,  // [0] water_present
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [15:0]                           rsp_tdata,  // [15:0] drive
   output logic [0:0]                            rsp_tuser,  // [0] drive_saturated
   input  logic                                  csr_we,
   input  logic [pidhc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pidhc_pkg::GAIN_W-1:0]          csr_wdata
);

   localparam int ENTRY_W = pidhc_pkg::ERR_W + pidhc_pkg::DERIV_W + SUM_WIDTH + 1;

   logic [pidhc_pkg::SAMPLE_W-1:0] setpoint_ff;
   pidhc_pkg::gains_type           gains_ff;

   logic               push, queue_ready, pop_valid, back_ready;
   logic [ENTRY_W-1:0] push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff     <= pidhc_pkg::SETPOINT_RST;
         gains_ff.gain_p <= pidhc_pkg::GAIN_P_RST;
         gains_ff.gain_i <= pidhc_pkg::GAIN_I_RST;
         gains_ff.gain_d <= pidhc_pkg::GAIN_D_RST;
      end else if (csr_we) begin
         case (pidhc_pkg::csr_index_type'(csr_index))
            pidhc_pkg::CSR_SETPOINT: setpoint_ff <= csr_wdata[pidhc_pkg::SAMPLE_W-1:0];
            pidhc_pkg::CSR_GAIN_P:   gains_ff.gain_p <= csr_wdata;
            pidhc_pkg::CSR_GAIN_I:   gains_ff.gain_i <= csr_wdata;
            pidhc_pkg::CSR_GAIN_D:   gains_ff.gain_d <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   pidhc_front #(
      .SUM_WIDTH(SUM_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .setpoint   (setpoint_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .sample     (req_tdata),
      .water      (req_tuser[0]),
      .queue_ready(queue_ready),
      .push       (push),
      .push_data  (push_data)
   );

   pidhc_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(pidhc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .push_ready(queue_ready),
      .pop       (pop_valid & back_ready),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   pidhc_back #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
      .SUM_WIDTH     (SUM_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .gains    (gains_ff),
      .in_valid (pop_valid),
      .in_ready (back_ready),
      .in_data  (pop_data),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .drive    (rsp_tdata),
      .saturated(rsp_tuser[0])
   );

`ifndef SYNTHESIS
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (rsp_tdata == pidhc_pkg::DRIVE_MAX || rsp_tdata == pidhc_pkg::DRIVE_MIN))
      else $error("Saturated drive word is not at a range limit.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result word valid right after reset.");

   a_no_ready_in_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("Input not ready right after reset.");
`endif

endmodule

FILE: tb/pid_heater_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID heater controller testbench
// Streams temperature sample words into the controller under random idling
// and backpressure, predicts every drive word with an independent fixed-point
// PID model and compares the drive words field by field in order.
// ----------------------------------------------------------------------------
module pid_heater_controller_tb;

   localparam int     FRAC_BITS    = pidhc_pkg::GAIN_FRAC_BITS_DEF;
   localparam int     SUM_W        = pidhc_pkg::SUM_WIDTH_DEF;
   localparam longint TERM_CLAMP   = longint'(1) << 60;
   localparam longint SUM_MAX      = (longint'(1) << (SUM_W - 1)) - 1;
   localparam longint SUM_MIN      = -SUM_MAX - 1;
   localparam int     CYCLE_LIMIT  = 3000000;

   typedef struct packed {
      logic        saturated;
      logic [15:0] drive;
   } heater_drive_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [15:0]                       req_tdata = '0;
   logic [0:0]                        req_tuser = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [15:0]                       rsp_tdata;
   logic [0:0]                        rsp_tuser;
   logic                              csr_we = 1'b0;
   logic [pidhc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pidhc_pkg::GAIN_W-1:0]      csr_wdata = '0;

   // Controller settings and history as the block should hold them.
   logic signed [15:0] ctl_setpoint = pidhc_pkg::SETPOINT_RST;
   logic signed [23:0] ctl_gain_p   = pidhc_pkg::GAIN_P_RST;
   logic signed [23:0] ctl_gain_i   = pidhc_pkg::GAIN_I_RST;
   logic signed [23:0] ctl_gain_d   = pidhc_pkg::GAIN_D_RST;
   longint             last_error   = 0;
   longint             error_total  = 0;

   heater_drive_type drive_queue[$];
   int               fail_count         = 0;
   int               cycle_count        = 0;
   int               sender_gap_pct     = 0;
   int               receiver_stall_pct = 0;
   int               hold_cycles        = 0;

   pid_heater_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic heater_drive_type predict_drive(logic [15:0] sample_bits, logic water);
      longint           err, deriv, integ, total, level, next_sum;
      heater_drive_type res;
      res = '0;
      if (!water) return res;
      err   = longint'(ctl_setpoint) - longint'($signed(sample_bits));
      deriv = err - last_error;
      integ = longint'(ctl_gain_i) * error_total;
      if (integ > TERM_CLAMP) integ = TERM_CLAMP;
      else if (integ < -TERM_CLAMP) integ = -TERM_CLAMP;
      total = longint'(ctl_gain_p) * err + longint'(ctl_gain_d) * deriv + integ;
      level = total >>> FRAC_BITS;
      if (level > 32767) begin
         level = 32767;
         res.saturated = 1'b1;
      end else if (level < -32768) begin
         level = -32768;
         res.saturated = 1'b1;
      end
      res.drive = 16'(level);
      next_sum = error_total + err;
      if (next_sum > SUM_MAX) next_sum = SUM_MAX;
      if (next_sum < SUM_MIN) next_sum = SUM_MIN;
      error_total = next_sum;
      last_error  = err;
      return res;
   endfunction

   task automatic flag_mismatch(string field, longint want, longint got);
      fail_count++;
      $error("%s expected %0d actual %0d", field, want, got);
   endtask

   // Input words are predicted before output words are checked at each edge.
   always @(posedge clock) begin
      heater_drive_type want;
      if (!reset && req_tvalid && req_tready)
         drive_queue.push_back(predict_drive(req_tdata, req_tuser[0]));
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (drive_queue.size() == 0) begin
            fail_count++;
            $error("drive word with none expected: drive %0d", $signed(rsp_tdata));
         end else begin
            want = drive_queue.pop_front();
            if (rsp_tdata !== want.drive)
               flag_mismatch("drive", $signed(want.drive), $signed(rsp_tdata));
            if (rsp_tuser[0] !== want.saturated)
               flag_mismatch("drive_saturated", want.saturated, rsp_tuser[0]);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         rsp_tready  <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic send_word(logic [15:0] sample, logic water);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tuser  <= water;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (drive_queue.size() != 0) @(posedge clock);
   endtask

   task automatic put_reg(pidhc_pkg::csr_index_type idx, logic [23:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] sp, logic [23:0] gp, logic [23:0] gi,
                             logic [23:0] gd);
      drain_results();
      put_reg(pidhc_pkg::CSR_SETPOINT, {8'h00, sp});
      put_reg(pidhc_pkg::CSR_GAIN_P, gp);
      put_reg(pidhc_pkg::CSR_GAIN_I, gi);
      put_reg(pidhc_pkg::CSR_GAIN_D, gd);
      csr_we       <= 1'b0;
      ctl_setpoint = sp;
      ctl_gain_p   = gp;
      ctl_gain_i   = gi;
      ctl_gain_d   = gd;
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return ctl_setpoint + 16'($urandom_range(64)) - 16'd32;
         default: return ctl_setpoint + 16'($urandom_range(4096)) - 16'd2048;
      endcase
   endfunction

   function automatic logic [15:0] rand_setpoint();
      case ($urandom_range(4))
         0: return 16'h7fff;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] rand_gain();
      logic signed [23:0] g;
      g = 24'($urandom);
      case ($urandom_range(5))
         0: return 24'h000000;
         1: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
         default: return g >>> $urandom_range(23);
      endcase
   endfunction

   task automatic test_default_settings();
      send_word(16'd1600, 1'b1);
      send_word(16'd0, 1'b1);
      send_word(16'h8000, 1'b1);
      send_word(16'h7fff, 1'b0);
   endtask

   task automatic test_gain_extremes();
      set_config(16'h7fff, 24'h7fffff, 24'h000000, 24'h000000);
      send_word(16'h8000, 1'b1);
      set_config(16'h7fff, 24'h800000, 24'h000000, 24'h000000);
      send_word(16'h8000, 1'b1);
      set_config(16'h8000, 24'h000000, 24'h000000, 24'h7fffff);
      send_word(16'h7fff, 1'b1);
      send_word(16'h8000, 1'b1);
      set_config(16'h0000, 24'h000000, 24'h800000, 24'h800000);
      send_word(16'h7fff, 1'b1);
      send_word(16'h0000, 1'b1);
      send_word(16'h8000, 1'b1);
   endtask

   // Without water the history must stay put, so the derivative after the
   // dry word is taken against the error from before it.
   task automatic test_no_water();
      set_config(16'd100, 24'd65536, 24'd0, 24'd65536);
      send_word(16'h0000, 1'b1);
      send_word(16'h8000, 1'b0);
      send_word(16'h0000, 1'b1);
      send_word(16'h7fff, 1'b0);
   endtask

   // A negative total must round toward minus infinity.
   task automatic test_floor_rounding();
      set_config(16'd1, 24'hffffff, 24'd0, 24'd0);
      send_word(16'd0, 1'b1);
      send_word(16'd2, 1'b1);
   endtask

   // With only an integral gain of one least significant bit, the drive follows
   // the error sum shifted down by the gain fraction bits as it grows, then falls back through zero.
   task automatic test_integral_sum();
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      set_config(16'h7fff, 24'd0, 24'd1, 24'd0);
      repeat (60) send_word(16'h8000, 1'b1);
      set_config(16'h8000, 24'd0, 24'd1, 24'd0);
      repeat (120) send_word(16'h7fff, 1'b1);
   endtask

   task automatic test_backpressure();
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      set_config(16'd1600, 24'd1311, 24'd300, 24'(-2000));
      hold_cycles = 150;
      repeat (24) send_word(rand_sample(), 1'b1);
      drain_results();
      repeat (12) send_word(rand_sample(), $urandom_range(99) < 85);
   endtask

   task automatic test_random_traffic(int gap_pct, int stall_pct, int count);
      sender_gap_pct     = gap_pct;
      receiver_stall_pct = stall_pct;
      repeat (3) begin
         set_config(rand_setpoint(), rand_gain(), rand_gain(), rand_gain());
         repeat (count / 3) send_word(rand_sample(), $urandom_range(99) < 85);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_settings();
      test_gain_extremes();
      test_no_water();
      test_floor_rounding();
      test_backpressure();
      test_random_traffic(34, 80, 240);
      test_random_traffic(80, 34, 240);
      test_random_traffic(0, 0, 240);
      test_integral_sum();
      drain_results();
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
